// File: rtl/core/kpd_pkg.sv
// package: shared types and constants for the keypad packet key decoder
`timescale 1ns / 1ps

package kpd_pkg;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int KEY_W    = 6;

    // frame status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_COLLECT  = 2'd0,
        ST_SYNC_ERR = 2'd1,
        ST_DONE     = 2'd2
    } frame_status_t;

    // packet layout
    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h55;
    localparam int IDX_ADDR  = 2;
    localparam int IDX_OP_HI = 3;
    localparam int IDX_OP_LO = 4;
    localparam int IDX_DATA  = 5;

    // opcode high values
    localparam logic [BYTE_W-1:0] OPH_DIR    = 8'h00;
    localparam logic [BYTE_W-1:0] OPH_ENTER  = 8'h01;
    localparam logic [BYTE_W-1:0] OPH_RETURN = 8'h02;
    localparam logic [BYTE_W-1:0] OPH_FUNC   = 8'h20;
    localparam logic [BYTE_W-1:0] OPH_SEARCH = 8'h25;
    localparam logic [BYTE_W-1:0] OPH_PAUSE  = 8'h80;

    // opcode low values under the direction group
    localparam logic [BYTE_W-1:0] OPL_CLEAR = 8'h00;
    localparam logic [BYTE_W-1:0] OPL_RIGHT = 8'h02;
    localparam logic [BYTE_W-1:0] OPL_LEFT  = 8'h04;
    localparam logic [BYTE_W-1:0] OPL_UP    = 8'h08;
    localparam logic [BYTE_W-1:0] OPL_DOWN  = 8'h10;
    localparam logic [BYTE_W-1:0] OPL_FF    = 8'h20;
    localparam logic [BYTE_W-1:0] OPL_RF    = 8'h40;
    localparam logic [BYTE_W-1:0] OPL_SETUP = 8'h5D;

    // function key data range
    localparam logic [BYTE_W-1:0] FUNC_DATA_MIN = 8'h01;
    localparam logic [BYTE_W-1:0] FUNC_DATA_MAX = 8'h17;

    // key codes
    localparam logic [KEY_W-1:0] KEY_NONE     = 6'd0;
    localparam logic [KEY_W-1:0] KEY_RIGHT    = 6'd1;
    localparam logic [KEY_W-1:0] KEY_LEFT     = 6'd2;
    localparam logic [KEY_W-1:0] KEY_FF       = 6'd3;
    localparam logic [KEY_W-1:0] KEY_RF       = 6'd4;
    localparam logic [KEY_W-1:0] KEY_UP       = 6'd5;
    localparam logic [KEY_W-1:0] KEY_DOWN     = 6'd6;
    localparam logic [KEY_W-1:0] KEY_SETUP    = 6'd7;
    localparam logic [KEY_W-1:0] KEY_ENTER    = 6'd8;
    localparam logic [KEY_W-1:0] KEY_RETURN   = 6'd9;
    localparam logic [KEY_W-1:0] KEY_FUNC_OFS = 6'd9;
    localparam logic [KEY_W-1:0] KEY_SEARCH   = 6'd33;
    localparam logic [KEY_W-1:0] KEY_PAUSE    = 6'd34;

endpackage

// File: rtl/core/kpd_in_if.sv
// interface: input byte channel
`timescale 1ns / 1ps

interface kpd_in_if;
    import kpd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    logic              line_error;
    logic              in_playback;

    modport source (output valid, output rx_byte, output line_error, output in_playback,
                    input ready);
    modport sink   (input valid, input rx_byte, input line_error, input in_playback,
                    output ready);
endinterface

// File: rtl/core/kpd_out_if.sv
// interface: decoded result channel
`timescale 1ns / 1ps

interface kpd_out_if;
    import kpd_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] frame_status;
    logic [KEY_W-1:0]    key_code;

    modport source (output valid, output frame_status, output key_code, input ready);
    modport sink   (input valid, input frame_status, input key_code, output ready);
endinterface

// File: rtl/core/kpd_cfg_if.sv
// interface: configuration write channel
`timescale 1ns / 1ps

interface kpd_cfg_if;
    import kpd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/keypad_packet_key_decoder_top.sv
// top level: keypad packet collector and key decoder
//
// Usage: serial keyboard bytes enter on in_ch, one word per byte, with a
// line error flag and the recorder playback flag. Every accepted word gives
// exactly one word on out_ch: frame status (collecting, sync/line error,
// packet complete) and, on a complete packet, the decoded key code.
// cfg_ch writes the device address byte; it is always ready and is meant
// to be written while no word is in flight.
// Path: an accepted input word is held in the input register, then it is
// decoded into the result register, which drives out_ch.
// Throughput: one word per cycle while out_ch is not stalled; the decode,
// key latch and byte counter update together.
// A stalled receiver holds the result register; the input register still
// takes one more word, then in_ch.ready drops until out_ch drains.
// Reset clears the byte counter, the key latch, the device address and
// both valid flags; captured packet bytes need no reset since each is
// written before the decode reads it.
`timescale 1ns / 1ps

module keypad_packet_key_decoder_top #(
    parameter int PACKET_LENGTH = 11
) (
    input  logic         clk,
    input  logic         rst_n,
    kpd_in_if.sink       in_ch,
    kpd_out_if.source    out_ch,
    kpd_cfg_if.sink      cfg_ch
);
    import kpd_pkg::*;

    localparam int CNT_W = $clog2(PACKET_LENGTH);
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(PACKET_LENGTH - 1);

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_err_reg;
    logic              in_pb_reg;

    // frame state
    logic [CNT_W-1:0]  byte_count_reg, byte_count_next;
    logic              key_latch_reg, key_latch_next;
    logic [BYTE_W-1:0] device_address_reg;
    logic [BYTE_W-1:0] addr_reg, op_hi_reg, op_lo_reg, data_reg;

    // result register
    logic                out_valid_reg;
    frame_status_t       status_reg, status_next;
    logic [KEY_W-1:0]    key_reg, key_next;

    logic advance;
    logic in_fire;
    logic key_raw_latched;
    logic [KEY_W-1:0] key_raw;
    logic key_play_only;
    logic key_clear;

    assign advance   = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = !in_valid_reg || advance;
    assign in_fire   = in_ch.valid && in_ch.ready;
    assign cfg_ch.ready = 1'b1;

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.frame_status = status_reg;
    assign out_ch.key_code     = key_reg;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg <= '0;
        end
        else if (cfg_ch.valid)
        begin
            device_address_reg <= cfg_ch.data;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_byte_reg <= in_ch.rx_byte;
            in_err_reg  <= in_ch.line_error;
            in_pb_reg   <= in_ch.in_playback;
        end
    end

    // key table lookup from captured packet bytes
    always_comb
    begin
        key_raw         = KEY_NONE;
        key_raw_latched = 1'b0;
        key_play_only   = 1'b0;
        key_clear       = 1'b0;
        unique case (op_hi_reg)
            OPH_DIR:
            begin
                unique case (op_lo_reg)
                    OPL_RIGHT:
                    begin
                        key_raw = KEY_RIGHT;
                        key_raw_latched = 1'b1;
                    end
                    OPL_LEFT:
                    begin
                        key_raw = KEY_LEFT;
                        key_raw_latched = 1'b1;
                    end
                    OPL_UP:
                    begin
                        key_raw = KEY_UP;
                        key_raw_latched = 1'b1;
                    end
                    OPL_DOWN:
                    begin
                        key_raw = KEY_DOWN;
                        key_raw_latched = 1'b1;
                    end
                    OPL_FF:
                    begin
                        key_raw = KEY_FF;
                        key_raw_latched = 1'b1;
                        key_play_only = 1'b1;
                    end
                    OPL_RF:
                    begin
                        key_raw = KEY_RF;
                        key_raw_latched = 1'b1;
                        key_play_only = 1'b1;
                    end
                    OPL_SETUP: key_raw = KEY_SETUP;
                    OPL_CLEAR: key_clear = 1'b1;
                    default:   key_raw = KEY_NONE;
                endcase
            end
            OPH_ENTER:
            begin
                key_raw = KEY_ENTER;
                key_raw_latched = 1'b1;
            end
            OPH_RETURN:
            begin
                key_raw = KEY_RETURN;
                key_raw_latched = 1'b1;
            end
            OPH_FUNC:
            begin
                if (data_reg >= FUNC_DATA_MIN && data_reg <= FUNC_DATA_MAX)
                begin
                    key_raw = data_reg[KEY_W-1:0] + KEY_FUNC_OFS;
                end
            end
            OPH_SEARCH: key_raw = KEY_SEARCH;
            OPH_PAUSE:  key_raw = KEY_PAUSE;
            default:    key_raw = KEY_NONE;
        endcase
    end

    // frame control and latch update for the word in the input register
    always_comb
    begin
        byte_count_next = byte_count_reg;
        key_latch_next  = key_latch_reg;
        status_next     = ST_COLLECT;
        key_next        = KEY_NONE;
        if (in_err_reg)
        begin
            byte_count_next = '0;
            status_next     = ST_SYNC_ERR;
        end
        else if (byte_count_reg == '0 && in_byte_reg != SYNC_BYTE)
        begin
            status_next = ST_SYNC_ERR;
        end
        else if (byte_count_reg == LAST_IDX)
        begin
            byte_count_next = '0;
            status_next     = ST_DONE;
            if (addr_reg == device_address_reg)
            begin
                if (key_clear)
                begin
                    key_latch_next = 1'b0;
                end
                else if (key_raw_latched)
                begin
                    if (!key_latch_reg && (!key_play_only || in_pb_reg))
                    begin
                        key_next       = key_raw;
                        key_latch_next = 1'b1;
                    end
                end
                else
                begin
                    key_next = key_raw;
                end
            end
        end
        else
        begin
            byte_count_next = byte_count_reg + 1'b1;
        end
    end

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            key_latch_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                byte_count_reg <= byte_count_next;
                key_latch_reg  <= key_latch_next;
            end
        end
    end

    // captured packet bytes and result payload
    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            status_reg <= status_next;
            key_reg    <= key_next;
            if (!in_err_reg)
            begin
                if (byte_count_reg == CNT_W'(IDX_ADDR))  addr_reg  <= in_byte_reg;
                if (byte_count_reg == CNT_W'(IDX_OP_HI)) op_hi_reg <= in_byte_reg;
                if (byte_count_reg == CNT_W'(IDX_OP_LO)) op_lo_reg <= in_byte_reg;
                if (byte_count_reg == CNT_W'(IDX_DATA))  data_reg  <= in_byte_reg;
            end
        end
    end

endmodule
